/* rtl/core/twap_pkg.sv */
// shared types and constants of the time-weighted quote averager
package twap_pkg;

  localparam int RingDepthDef       = 1024;
  localparam int FallbackPeriodsDef = 10;

  localparam int TimeW   = 48;
  localparam int PriceW  = 32;
  localparam int QtyW    = 32;
  localparam int MeanW   = 48;
  localparam int PeriodW = 32;
  localparam int RetainW = 8;
  localparam int FracW   = 16;
  localparam int KeepW   = PeriodW + RetainW;
  localparam int PsumW   = PriceW + 1;
  localparam int DtLoW   = 24;
  localparam int DtHiW   = TimeW - DtLoW;
  localparam int ProdW   = PsumW + DtLoW;
  localparam int AccW    = PsumW + TimeW + 1;
  localparam int NumW    = AccW + FracW;
  localparam int DenW    = TimeW + 2;
  localparam int CfgW    = 32;

  localparam logic [PeriodW-1:0] PeriodRst = 32'd1000000;
  localparam logic [RetainW-1:0] RetainRst = 8'd2;

  typedef enum logic {
    CfgPeriod    = 1'b0,
    CfgRetention = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OpAdd   = 1'b0,
    OpQuery = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    StIdle,
    StAddWr,
    StEvRd,
    StEvChk,
    StQRd,
    StQChk,
    StQMul0,
    StQMul1,
    StQMul2,
    StQNext,
    StQEnd,
    StQDiv,
    StQDone
  } state_e;

  typedef struct packed {
    logic [TimeW-1:0]  time_us;
    logic [PriceW-1:0] ask_price;
    logic [PriceW-1:0] bid_price;
    logic [QtyW-1:0]   ask_qty;
    logic [QtyW-1:0]   bid_qty;
  } quote_t;

endpackage

/* rtl/core/twap_ring_mem.sv */
// quote ring storage, one write port and one registered read port
module twap_ring_mem import twap_pkg::*; #(
  parameter int DEPTH = RingDepthDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  quote_t                   wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output quote_t                   rdata_o
);

  quote_t mem_q [DEPTH];
  quote_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/twap_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
module twap_div import twap_pkg::*; #(
  parameter int NUM_W = NumW,
  parameter int DEN_W = DenW,
  parameter int Q_W   = MeanW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [Q_W-1:0]   quot_o
);

  localparam int CntW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [Q_W-1:0]   quot_q;
  logic [CntW-1:0]  cnt_q;
  logic             done_q;
  logic [DEN_W:0]   rem_sh;
  logic             qbit;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign qbit   = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CntW'(NUM_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (cnt_q != '0) begin
      num_q  <= {num_q[NUM_W-2:0], 1'b0};
      rem_q  <= qbit ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
      quot_q <= {quot_q[Q_W-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* rtl/core/windowed_twap_quote_averager_unit.sv */
// top level: quote ring, window scan, trapezoidal mean and fallback
// add: accept, write, then a read and a check of the oldest entry, repeated (one more
//   check than evictions; when the ring empties, a final read instead of a check)
// query: entries read one at a time from the ring port, each with read, check and next
//   steps plus multiply steps in the window, then serial division when the span is nonzero
// one word is worked on at a time; a finished result waits in the output register
// reset (async, active low) empties the ring, clears the fallback and loads config defaults
module windowed_twap_quote_averager_unit import twap_pkg::*; #(
  parameter int RING_DEPTH       = RingDepthDef,
  parameter int FALLBACK_PERIODS = FallbackPeriodsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic [TimeW-1:0]   time_us_i,
  input  logic [PriceW-1:0]  ask_price_i,
  input  logic [PriceW-1:0]  bid_price_i,
  input  logic [QtyW-1:0]    ask_quantity_i,
  input  logic [QtyW-1:0]    bid_quantity_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o,
  output logic [MeanW-1:0]   ask_mean_o,
  output logic [MeanW-1:0]   bid_mean_o,
  output logic [QtyW-1:0]    last_ask_quantity_o,
  output logic [QtyW-1:0]    last_bid_quantity_o,
  output logic [TimeW-1:0]   result_time_o
);

  localparam int IdxW = $clog2(RING_DEPTH);
  localparam int CntW = $clog2(RING_DEPTH + 1);
  localparam int SumW = IdxW + 1;

  // configuration
  logic [PeriodW-1:0] period_q;
  logic [RetainW-1:0] retain_q;

  // ring bookkeeping
  logic [IdxW-1:0] oldest_q;
  logic [CntW-1:0] count_q;
  logic [KeepW-1:0] keep_q;

  // captured word
  logic   is_query;
  quote_t item_q;

  state_e state_q, state_d;

  // window scan
  logic [IdxW-1:0]   rd_ptr_q;
  logic [CntW-1:0]   k_q;
  logic              started_q;
  logic [TimeW-1:0]  start_t_q, latest_q;
  logic [PriceW-1:0] first_ask_q, first_bid_q, prev_ask_q, prev_bid_q;
  logic [QtyW-1:0]   first_aq_q, first_bq_q, last_aq_q, last_bq_q;
  logic [PsumW-1:0]  sum_a_q, sum_b_q;
  logic [TimeW-1:0]  dt_q;
  logic [ProdW-1:0]  prod_a_q, prod_b_q;
  logic [AccW-1:0]   acc_a_q, acc_b_q;
  logic              empty_q;

  // pending result
  logic             res_found_q, res_upd_q;
  logic [MeanW-1:0] res_ask_q, res_bid_q;
  logic [QtyW-1:0]  res_aq_q, res_bq_q;

  // fallback
  logic             fb_valid_q;
  logic [TimeW-1:0] fb_time_q;
  logic [MeanW-1:0] fb_ask_q, fb_bid_q;
  logic [QtyW-1:0]  fb_aq_q, fb_bq_q;

  // output register
  logic             out_valid_q, out_found_q;
  logic [MeanW-1:0] out_ask_q, out_bid_q;
  logic [QtyW-1:0]  out_aq_q, out_bq_q;
  logic [TimeW-1:0] out_time_q;

  // memory port
  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  quote_t          rd_quote;

  logic             div_start, div_a_done, div_b_done;
  logic [MeanW-1:0] quot_a, quot_b;

  logic            in_fire, ring_full, out_free, last_entry;
  logic [SumW-1:0] tail_sum;
  logic [IdxW-1:0] tail_idx, oldest_nxt, rd_ptr_nxt;
  logic [TimeW:0]  win_lo_sum, keep_sum, fb_limit;
  logic            rd_after_q, rd_in_lo;
  logic [DenW-1:0] den;

  assign in_fire   = in_valid_i && in_ready_o;
  assign is_query  = (opcode_i == OpQuery);
  assign ring_full = (count_q == CntW'(RING_DEPTH));
  assign out_free  = !out_valid_q || out_ready_i;
  assign last_entry = ((k_q + CntW'(1)) == count_q);

  // write slot when the ring has room: oldest plus count, wrapped
  assign tail_sum = SumW'(oldest_q) + SumW'(count_q);
  assign tail_idx = (tail_sum >= SumW'(RING_DEPTH)) ?
                    IdxW'(tail_sum - SumW'(RING_DEPTH)) : IdxW'(tail_sum);
  assign oldest_nxt = (oldest_q == IdxW'(RING_DEPTH - 1)) ? '0 : oldest_q + IdxW'(1);
  assign rd_ptr_nxt = (rd_ptr_q == IdxW'(RING_DEPTH - 1)) ? '0 : rd_ptr_q + IdxW'(1);

  // window membership of the entry just read
  assign win_lo_sum = {1'b0, rd_quote.time_us} + (TimeW+1)'(period_q);
  assign rd_in_lo   = (win_lo_sum > {1'b0, item_q.time_us});
  assign rd_after_q = (rd_quote.time_us > item_q.time_us);

  // retention check of the oldest entry
  assign keep_sum = {1'b0, rd_quote.time_us} + (TimeW+1)'(keep_q);
  assign fb_limit = {1'b0, fb_time_q} +
                    (TimeW+1)'(KeepW'(period_q) * KeepW'(FALLBACK_PERIODS));

  assign den = {(DenW-1)'(latest_q - start_t_q), 1'b0};

  // config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodRst;
      retain_q <= RetainRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgPeriod:    period_q <= cfg_data_i[PeriodW-1:0];
        CfgRetention: retain_q <= cfg_data_i[RetainW-1:0];
        default:      ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (!is_query)           state_d = StAddWr;
          else if (count_q == '0)  state_d = StQEnd;
          else                     state_d = StQRd;
        end
      end
      StAddWr: state_d = StEvRd;
      StEvRd:  state_d = (count_q == '0) ? StIdle : StEvChk;
      StEvChk: state_d = (keep_sum <= {1'b0, item_q.time_us}) ? StEvRd : StIdle;
      StQRd:   state_d = StQChk;
      StQChk: begin
        if (!started_q) begin
          if (rd_in_lo && rd_after_q) state_d = StQEnd;
          else                        state_d = StQNext;
        end else if (rd_after_q) begin
          state_d = StQEnd;
        end else begin
          state_d = StQMul0;
        end
      end
      StQMul0: state_d = StQMul1;
      StQMul1: state_d = StQMul2;
      StQMul2: state_d = StQNext;
      StQNext: state_d = last_entry ? StQEnd : StQRd;
      StQEnd: begin
        if (started_q && !empty_q && (latest_q != start_t_q)) state_d = StQDiv;
        else                                                   state_d = StQDone;
      end
      StQDiv:  state_d = div_a_done ? StQDone : StQDiv;
      StQDone: state_d = out_free ? StIdle : StQDone;
      default: state_d = StIdle;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = (state_q == StIdle);
    mem_we     = (state_q == StAddWr);
    mem_waddr  = ring_full ? oldest_q : tail_idx;
    mem_re     = 1'b0;
    mem_raddr  = rd_ptr_q;
    div_start  = 1'b0;
    case (state_q)
      StEvRd: begin
        mem_re    = (count_q != '0);
        mem_raddr = oldest_q;
      end
      StQRd: mem_re = 1'b1;
      StQEnd: div_start = started_q && !empty_q && (latest_q != start_t_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // ring pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      count_q  <= '0;
    end else begin
      case (state_q)
        StAddWr: begin
          if (ring_full) oldest_q <= oldest_nxt;
          else           count_q  <= count_q + CntW'(1);
        end
        StEvChk: begin
          if (keep_sum <= {1'b0, item_q.time_us}) begin
            oldest_q <= oldest_nxt;
            count_q  <= count_q - CntW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // word capture and window scan datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      empty_q   <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          started_q <= 1'b0;
          empty_q   <= 1'b0;
        end
        StQChk: begin
          if (!started_q && rd_in_lo) begin
            if (rd_after_q) empty_q   <= 1'b1;
            else            started_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          item_q.time_us   <= time_us_i;
          item_q.ask_price <= ask_price_i;
          item_q.bid_price <= bid_price_i;
          item_q.ask_qty   <= ask_quantity_i;
          item_q.bid_qty   <= bid_quantity_i;
          keep_q           <= KeepW'(period_q) * KeepW'(retain_q);
          rd_ptr_q         <= oldest_q;
          k_q              <= '0;
          acc_a_q          <= '0;
          acc_b_q          <= '0;
        end
      end
      StQChk: begin
        if (!started_q) begin
          if (rd_in_lo && !rd_after_q) begin
            start_t_q   <= rd_quote.time_us;
            latest_q    <= rd_quote.time_us;
            first_ask_q <= rd_quote.ask_price;
            first_bid_q <= rd_quote.bid_price;
            first_aq_q  <= rd_quote.ask_qty;
            first_bq_q  <= rd_quote.bid_qty;
            prev_ask_q  <= rd_quote.ask_price;
            prev_bid_q  <= rd_quote.bid_price;
            last_aq_q   <= rd_quote.ask_qty;
            last_bq_q   <= rd_quote.bid_qty;
          end
        end else if (!rd_after_q) begin
          // a backward step in time counts as zero span
          if (rd_quote.time_us > latest_q) begin
            dt_q     <= rd_quote.time_us - latest_q;
            latest_q <= rd_quote.time_us;
          end else begin
            dt_q <= '0;
          end
          sum_a_q    <= PsumW'(prev_ask_q) + PsumW'(rd_quote.ask_price);
          sum_b_q    <= PsumW'(prev_bid_q) + PsumW'(rd_quote.bid_price);
          prev_ask_q <= rd_quote.ask_price;
          prev_bid_q <= rd_quote.bid_price;
          last_aq_q  <= rd_quote.ask_qty;
          last_bq_q  <= rd_quote.bid_qty;
        end
      end
      StQMul0: begin
        prod_a_q <= ProdW'(sum_a_q) * ProdW'(dt_q[DtLoW-1:0]);
        prod_b_q <= ProdW'(sum_b_q) * ProdW'(dt_q[DtLoW-1:0]);
      end
      StQMul1: begin
        acc_a_q  <= acc_a_q + AccW'(prod_a_q);
        acc_b_q  <= acc_b_q + AccW'(prod_b_q);
        prod_a_q <= ProdW'(sum_a_q) * ProdW'(dt_q[TimeW-1:DtLoW]);
        prod_b_q <= ProdW'(sum_b_q) * ProdW'(dt_q[TimeW-1:DtLoW]);
      end
      StQMul2: begin
        acc_a_q <= acc_a_q + (AccW'(prod_a_q) << DtLoW);
        acc_b_q <= acc_b_q + (AccW'(prod_b_q) << DtLoW);
      end
      StQNext: begin
        k_q      <= k_q + CntW'(1);
        rd_ptr_q <= rd_ptr_nxt;
      end
      default: ;
    endcase
  end

  // pending result
  always_ff @(posedge clk_i) begin
    case (state_q)
      StQEnd: begin
        res_upd_q   <= 1'b0;
        res_found_q <= 1'b0;
        res_ask_q   <= '0;
        res_bid_q   <= '0;
        res_aq_q    <= '0;
        res_bq_q    <= '0;
        if (count_q == '0) begin
          // empty ring: nothing, fallback not consulted
        end else if (!started_q || empty_q) begin
          if (fb_valid_q && ({1'b0, item_q.time_us} <= fb_limit)) begin
            res_found_q <= 1'b1;
            res_ask_q   <= fb_ask_q;
            res_bid_q   <= fb_bid_q;
            res_aq_q    <= fb_aq_q;
            res_bq_q    <= fb_bq_q;
          end
        end else if (latest_q == start_t_q) begin
          // single quote or zero span: first quote as is
          res_found_q <= 1'b1;
          res_upd_q   <= 1'b1;
          res_ask_q   <= {first_ask_q, FracW'(0)};
          res_bid_q   <= {first_bid_q, FracW'(0)};
          res_aq_q    <= first_aq_q;
          res_bq_q    <= first_bq_q;
        end else begin
          res_found_q <= 1'b1;
          res_upd_q   <= 1'b1;
          res_aq_q    <= last_aq_q;
          res_bq_q    <= last_bq_q;
        end
      end
      StQDiv: begin
        if (div_a_done) begin
          res_ask_q <= quot_a;
          res_bid_q <= quot_b;
        end
      end
      default: ;
    endcase
  end

  // fallback and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      fb_valid_q  <= 1'b0;
      fb_time_q   <= '0;
      fb_ask_q    <= '0;
      fb_bid_q    <= '0;
      fb_aq_q     <= '0;
      fb_bq_q     <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == StQDone) && out_free) begin
        out_valid_q <= 1'b1;
        if (res_upd_q) begin
          fb_valid_q <= 1'b1;
          fb_time_q  <= item_q.time_us;
          fb_ask_q   <= res_ask_q;
          fb_bid_q   <= res_bid_q;
          fb_aq_q    <= res_aq_q;
          fb_bq_q    <= res_bq_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == StQDone) && out_free) begin
      out_found_q <= res_found_q;
      out_ask_q   <= res_ask_q;
      out_bid_q   <= res_bid_q;
      out_aq_q    <= res_aq_q;
      out_bq_q    <= res_bq_q;
      out_time_q  <= item_q.time_us;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign found_o             = out_found_q;
  assign ask_mean_o          = out_ask_q;
  assign bid_mean_o          = out_bid_q;
  assign last_ask_quantity_o = out_aq_q;
  assign last_bid_quantity_o = out_bq_q;
  assign result_time_o       = out_time_q;

  twap_ring_mem #(
    .DEPTH(RING_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (item_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd_quote)
  );

  // ask and bid divide in lockstep, den = 2 * span
  twap_div u_div_ask (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({acc_a_q, FracW'(0)}),
    .den_i   (den),
    .done_o  (div_a_done),
    .quot_o  (quot_a)
  );

  twap_div u_div_bid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({acc_b_q, FracW'(0)}),
    .den_i   (den),
    .done_o  (div_b_done),
    .quot_o  (quot_b)
  );

  // ring never holds more than its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(RING_DEPTH))
    else $error("ring count above depth");

  // both dividers finish together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_a_done == div_b_done)
    else $error("dividers out of step");

  // a new result is loaded only from the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StQDone))
    else $error("result loaded outside done state");

  // adds never leave a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StAddWr) |=> !$rose(out_valid_q))
    else $error("add produced a result");

endmodule

/* tb/tb_windowed_twap_quote_averager_unit.sv */
// testbench for the windowed time-weighted quote averager
`timescale 1ns / 100ps

module tb_windowed_twap_quote_averager_unit;
  import twap_pkg::*;

  localparam int Ring      = 1024;
  localparam int FbPeriods = 10;
  localparam int CycleCap  = 40000000;
  localparam int ExpDepth  = 16;

  // one result word as the block should deliver it
  typedef struct {
    logic             found;
    logic [MeanW-1:0] ask_mean;
    logic [MeanW-1:0] bid_mean;
    logic [QtyW-1:0]  ask_qty;
    logic [QtyW-1:0]  bid_qty;
    logic [TimeW-1:0] result_time;
  } twap_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_index_i;
  logic [CfgW-1:0]   cfg_data_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              opcode_i;
  logic [TimeW-1:0]  time_us_i;
  logic [PriceW-1:0] ask_price_i;
  logic [PriceW-1:0] bid_price_i;
  logic [QtyW-1:0]   ask_quantity_i;
  logic [QtyW-1:0]   bid_quantity_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              found_o;
  logic [MeanW-1:0]  ask_mean_o;
  logic [MeanW-1:0]  bid_mean_o;
  logic [QtyW-1:0]   last_ask_quantity_o;
  logic [QtyW-1:0]   last_bid_quantity_o;
  logic [TimeW-1:0]  result_time_o;

  windowed_twap_quote_averager_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .opcode_i, .time_us_i, .ask_price_i, .bid_price_i,
    .ask_quantity_i, .bid_quantity_i, .out_valid_o, .out_ready_i, .found_o,
    .ask_mean_o, .bid_mean_o, .last_ask_quantity_o, .last_bid_quantity_o,
    .result_time_o
  );

  // shadow copy of the quote ring, fallback and registers
  logic [63:0]       ring_time [Ring];
  logic [PriceW-1:0] ring_ask  [Ring];
  logic [PriceW-1:0] ring_bid  [Ring];
  logic [QtyW-1:0]   ring_aqty [Ring];
  logic [QtyW-1:0]   ring_bqty [Ring];
  int                ring_head;
  int                ring_count;
  logic              fb_valid;
  logic [63:0]       fb_time;
  logic [MeanW-1:0]  fb_ask;
  logic [MeanW-1:0]  fb_bid;
  logic [QtyW-1:0]   fb_aqty;
  logic [QtyW-1:0]   fb_bqty;
  logic [63:0]       cur_period;
  logic [63:0]       cur_retain;

  // expected result words, written at acceptance and read by the checker
  twap_result_t exp_words [ExpDepth];
  int           exp_wr;
  int           exp_rd;

  int          send_idle_pct;
  int          recv_stall_pct;
  int          errors;
  int          cycles;
  int          quotes_added;
  int          queries_sent;
  int          results_checked;
  int          found_count;
  logic [63:0] now_t;

  function automatic int words_owed();
    return exp_wr - exp_rd;
  endfunction

  // clock and cycle limit
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles,
               words_owed());
      $display("** windowed_twap_quote_averager_unit: FAILED **");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic int slot_of(int k);
    return (ring_head + k) % Ring;
  endfunction

  // shadow ring update and eviction for adds; trapezoidal mean over the window, fallback on an empty one
  task automatic predict_word(input op_e op, input logic [TimeW-1:0] t,
                              input logic [PriceW-1:0] ap, input logic [PriceW-1:0] bp,
                              input logic [QtyW-1:0] aq, input logic [QtyW-1:0] bq);
    int           w, s, e, f, l, c, p, k;
    logic [63:0]  keep, start_t, latest, dt, den, qt;
    logic [32:0]  psum;
    logic [127:0] sa, sb, quot;
    twap_result_t r;
    qt = {16'b0, t};
    if (op == OpAdd) begin
      keep = cur_period * cur_retain;
      if (ring_count >= Ring) begin
        w = ring_head;
        ring_head = slot_of(1);
      end else begin
        w = slot_of(ring_count);
        ring_count++;
      end
      ring_time[w] = qt;
      ring_ask[w]  = ap;
      ring_bid[w]  = bp;
      ring_aqty[w] = aq;
      ring_bqty[w] = bq;
      // oldest-first eviction of quotes past the retention span
      while (ring_count > 0 && ring_time[ring_head] + keep <= qt) begin
        ring_head = slot_of(1);
        ring_count--;
      end
      quotes_added++;
      return;
    end
    queries_sent++;
    r = '{1'b0, '0, '0, '0, '0, t};
    if (ring_count != 0) begin
      for (s = 0; s < ring_count; s++)
        if (ring_time[slot_of(s)] + cur_period > qt) break;
      for (e = s; e < ring_count; e++)
        if (ring_time[slot_of(e)] > qt) break;
      if (e == s) begin
        if (fb_valid && qt <= fb_time + cur_period * FbPeriods)
          r = '{1'b1, fb_ask, fb_bid, fb_aqty, fb_bqty, t};
      end else begin
        f = slot_of(s);
        l = slot_of(e - 1);
        start_t = ring_time[f];
        latest = start_t;
        sa = '0;
        sb = '0;
        for (k = s + 1; k < e; k++) begin
          c = slot_of(k);
          p = slot_of(k - 1);
          dt = (ring_time[c] > latest) ? ring_time[c] - latest : 64'd0;
          if (ring_time[c] > latest) latest = ring_time[c];
          psum = {1'b0, ring_ask[p]} + {1'b0, ring_ask[c]};
          sa += 128'(psum) * 128'(dt);
          psum = {1'b0, ring_bid[p]} + {1'b0, ring_bid[c]};
          sb += 128'(psum) * 128'(dt);
        end
        r.found = 1'b1;
        if (latest == start_t) begin
          // zero span or lone quote: first quote as is
          r.ask_mean = {ring_ask[f], 16'b0};
          r.bid_mean = {ring_bid[f], 16'b0};
          r.ask_qty  = ring_aqty[f];
          r.bid_qty  = ring_bqty[f];
        end else begin
          den = 2 * (latest - start_t);
          quot = (sa << FracW) / 128'(den);
          r.ask_mean = quot[MeanW-1:0];
          quot = (sb << FracW) / 128'(den);
          r.bid_mean = quot[MeanW-1:0];
          r.ask_qty  = ring_aqty[l];
          r.bid_qty  = ring_bqty[l];
        end
        fb_valid = 1'b1;
        fb_time  = qt;
        fb_ask   = r.ask_mean;
        fb_bid   = r.bid_mean;
        fb_aqty  = r.ask_qty;
        fb_bqty  = r.bid_qty;
      end
    end
    exp_words[exp_wr % ExpDepth] = r;
    exp_wr++;
  endtask

  // drop valid and let cycles pass
  task automatic hold_off(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // one input word through the valid/ready handshake, then predicted
  task automatic send_word(input op_e op, input logic [63:0] t,
                           input logic [PriceW-1:0] ap, input logic [PriceW-1:0] bp,
                           input logic [QtyW-1:0] aq, input logic [QtyW-1:0] bq);
    if ($urandom_range(99) < send_idle_pct) hold_off($urandom_range(1, 4));
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    time_us_i      <= t[TimeW-1:0];
    ask_price_i    <= ap;
    bid_price_i    <= bp;
    ask_quantity_i <= aq;
    bid_quantity_i <= bq;
    // ready is stable at the falling edge, so the next rising edge accepts
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    predict_word(op, t[TimeW-1:0], ap, bp, aq, bq);
  endtask

  task automatic add_quote(input logic [63:0] t, input logic [PriceW-1:0] ap,
                           input logic [PriceW-1:0] bp);
    send_word(OpAdd, t, ap, bp, $urandom, $urandom);
  endtask

  task automatic query_at(input logic [63:0] t);
    send_word(OpQuery, t, $urandom, $urandom, $urandom, $urandom);
  endtask

  // wait for every result and for the longest possible eviction run
  task automatic drain();
    in_valid_i <= 1'b0;
    while (words_owed() != 0) @(posedge clk_i);
    repeat (2 * Ring + 120) @(posedge clk_i);
  endtask

  // register write, only with the block idle
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgPeriod) cur_period = {32'b0, val};
    else cur_retain = {56'b0, val[RetainW-1:0]};
  endtask

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
  endtask

  // result checker: the word seen at the falling edge is taken at the next rising edge
  always @(negedge clk_i) begin
    twap_result_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (words_owed() == 0) begin
        errors++;
        $display("%0t: unexpected result word, time %0h", $time, result_time_o);
      end else begin
        w = exp_words[exp_rd % ExpDepth];
        exp_rd++;
        results_checked++;
        if (w.found) found_count++;
        if (found_o !== w.found) report_field("found", w.found, found_o);
        if (ask_mean_o !== w.ask_mean) report_field("ask_mean", w.ask_mean, ask_mean_o);
        if (bid_mean_o !== w.bid_mean) report_field("bid_mean", w.bid_mean, bid_mean_o);
        if (last_ask_quantity_o !== w.ask_qty)
          report_field("last_ask_quantity", w.ask_qty, last_ask_quantity_o);
        if (last_bid_quantity_o !== w.bid_qty)
          report_field("last_bid_quantity", w.bid_qty, last_bid_quantity_o);
        if (result_time_o !== w.result_time)
          report_field("result_time", w.result_time, result_time_o);
      end
    end
  end

  // query on an empty ring never consults the fallback
  task automatic test_empty_ring();
    query_at(0);
  endtask

  // lone quote, zero span and a real trapezoid at price extremes
  task automatic test_means();
    send_word(OpAdd, 1000, '1, '0, '1, '0);
    query_at(1000);
    send_word(OpAdd, 1000, 5, 7, 0, '1);
    query_at(1000);
    add_quote(5000, '1, '1);
    add_quote(9000, 0, 12345);
    query_at(9000);
    query_at(4999);
    now_t = 9000;
  endtask

  // fallback answers empty windows for ten periods, inclusive
  task automatic test_fallback();
    query_at(9000 + 5 * cur_period);
    query_at(9000 + FbPeriods * cur_period);
    query_at(9000 + FbPeriods * cur_period + 1);
  endtask

  // retention eviction under changed registers
  task automatic test_eviction();
    add_quote(9000 + 2 * cur_period, $urandom, $urandom);
    query_at(9000 + 2 * cur_period);
    write_reg(CfgRetention, 1);
    write_reg(CfgPeriod, 500);
    now_t = 9000 + 2 * 64'd1000000;
    add_quote(now_t + 200, $urandom, $urandom);
    add_quote(now_t + 700, $urandom, $urandom);
    now_t += 700;
    query_at(now_t);
  endtask

  // more quotes than ring entries: oldest ones overwritten
  task automatic test_full_ring();
    write_reg(CfgPeriod, '1);
    write_reg(CfgRetention, 255);
    for (int i = 1; i <= Ring + 6; i++) add_quote(now_t + i, $urandom, $urandom);
    now_t += Ring + 6;
    query_at(now_t);
    write_reg(CfgRetention, 1);
    now_t += 64'hFFFF_FFFF;
    add_quote(now_t, $urandom, $urandom);
    query_at(now_t);
  endtask

  // mostly ordered feed with random content, some stale quotes and odd queries
  task automatic run_random(input int n);
    logic [63:0] step, t;
    int          roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      step = cur_period / $urandom_range(1, 6);
      if (step == 0) step = 1;
      if (roll < 57) begin
        now_t += (step > 64'hFFFF_FFFF) ? {32'b0, $urandom} : $urandom_range(0, 2 * step);
        add_quote(now_t, $urandom, $urandom);
      end else if (roll < 60) begin
        t = now_t - $urandom_range(0, cur_period);
        add_quote(t > now_t ? 64'd0 : t, $urandom, $urandom);
      end else if (roll < 84) begin
        query_at(now_t + $urandom_range(0, cur_period - 1));
      end else if (roll < 93) begin
        query_at(now_t + cur_period * $urandom_range(1, 12) + $urandom_range(0, 3));
      end else if (roll < 97) begin
        t = now_t - $urandom_range(0, 3 * cur_period);
        query_at(t > now_t ? 64'd0 : t);
      end else begin
        query_at({$urandom, $urandom} & 64'hFFFF_FFFF_FFFF);
      end
    end
  endtask

  // top bit of time set: prices at max, then a query far in the past
  task automatic test_time_extremes();
    write_reg(CfgRetention, 255);
    send_word(OpAdd, 64'hFFFF_FFFF_FFFF, '1, '1, '1, '1);
    query_at(64'hFFFF_FFFF_FFFF);
    query_at(0);
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_index_i    <= CfgPeriod;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    opcode_i       <= OpAdd;
    time_us_i      <= '0;
    ask_price_i    <= '0;
    bid_price_i    <= '0;
    ask_quantity_i <= '0;
    bid_quantity_i <= '0;
    cycles = 0;
    errors = 0;
    quotes_added = 0;
    queries_sent = 0;
    results_checked = 0;
    found_count = 0;
    exp_wr = 0;
    exp_rd = 0;
    ring_head = 0;
    ring_count = 0;
    fb_valid = 1'b0;
    fb_time = '0;
    fb_ask = '0;
    fb_bid = '0;
    fb_aqty = '0;
    fb_bqty = '0;
    cur_period = 64'd1000000;
    cur_retain = 64'd2;
    now_t = 0;
    send_idle_pct = 27;
    recv_stall_pct = 50;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_ring();
    test_means();
    test_fallback();
    test_eviction();
    test_full_ring();

    write_reg(CfgPeriod, 1000);
    write_reg(CfgRetention, 3);
    run_random(240);

    send_idle_pct = 50;
    recv_stall_pct = 27;
    write_reg(CfgPeriod, 1);
    write_reg(CfgRetention, 1);
    run_random(120);
    write_reg(CfgPeriod, '1);
    write_reg(CfgRetention, 2);
    run_random(120);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(CfgPeriod, 100);
    write_reg(CfgRetention, 255);
    run_random(220);

    test_time_extremes();
    drain();

    $display("covered %0d quote adds and %0d queries, %0d results checked (%0d found)",
             quotes_added, queries_sent, results_checked, found_count);
    $display("register extremes, full ring, eviction, fallback and zero-span windows hit");
    if (errors == 0) begin
      $display("** windowed_twap_quote_averager_unit: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** windowed_twap_quote_averager_unit: FAILED **");
    end
    $finish;
  end

endmodule
